>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/prd_pkg.sv
// ---------------------------------------------------------------------------
// prd_pkg
// shared types and constants of the packbits row decoder
// ---------------------------------------------------------------------------
package prd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_ROW_WIDTH   = 4096;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam logic [8:0] RUN_BASE    = 9'd257;
  localparam logic [7:0] HDR_RUN_BIT = 8'h80;
  localparam logic [7:0] NIB_MASK    = 8'h0F;
  localparam int         NIB_SHIFT   = 4;

  typedef enum logic [1:0] {
    ACT_PAL_WRITE = 2'd0,
    ACT_ROW_START = 2'd1,
    ACT_ROW_DATA  = 2'd2,
    ACT_NOP       = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_RUN     = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  localparam logic CFG_NIBBLE_MODE = 1'b0;
  localparam logic CFG_ROW_WIDTH   = 1'b1;

  typedef struct packed {
    action_t      action;
    logic [7:0]   data_byte;
    logic [7:0]   palette_index;
    logic [7:0]   palette_value;
    logic [15:0]  row_byte_count;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  count;
    logic [11:0] col;
  } res_t;

  typedef struct packed {
    logic       go;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  typedef struct packed {
    logic       we;
    logic [7:0] widx;
    logic [7:0] wval;
    logic       re;
    logic [7:0] ridx0;
    logic [7:0] ridx1;
  } pal_req_t;

endpackage

>>> sv/prd_ifs.sv
// ---------------------------------------------------------------------------
// prd_ifs
// item channels and configuration write channel
// ---------------------------------------------------------------------------
interface prd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [7:0]  palette_value;
  logic [15:0] row_byte_count;

  modport source (output valid, action, data_byte, palette_index, palette_value,
                  row_byte_count, input ready);
  modport sink   (input valid, action, data_byte, palette_index, palette_value,
                  row_byte_count, output ready);
endinterface

interface prd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_color;
  logic [8:0]  repeat_count;
  logic [11:0] start_column;
  logic        last;

  modport source (output valid, pixel_color, repeat_count, start_column, last,
                  input ready);
  modport sink   (input valid, pixel_color, repeat_count, start_column, last,
                  output ready);
endinterface

interface prd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/prd_palette.sv
// ---------------------------------------------------------------------------
// prd_palette
// palette table, one write port and two registered read ports
// ---------------------------------------------------------------------------
module prd_palette (
  input  logic            clk,
  input  prd_pkg::pal_req_t req,
  output logic [7:0]      rdata0,
  output logic [7:0]      rdata1
);
  import prd_pkg::*;

  logic [7:0] mem [PALETTE_ENTRIES];
  logic [7:0] rd0_r, rd1_r;
  logic       ok0_r, ok1_r;

  always_ff @(posedge clk) begin
    if (req.we && (32'(req.widx) < PALETTE_ENTRIES)) begin
      mem[req.widx[PAL_AW-1:0]] <= req.wval;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd0_r <= mem[req.ridx0[PAL_AW-1:0]];
      rd1_r <= mem[req.ridx1[PAL_AW-1:0]];
      ok0_r <= 32'(req.ridx0) < PALETTE_ENTRIES;
      ok1_r <= 32'(req.ridx1) < PALETTE_ENTRIES;
    end
  end

  assign rdata0 = ok0_r ? rd0_r : 8'd0;
  assign rdata1 = ok1_r ? rd1_r : 8'd0;

endmodule

>>> sv/prd_decode.sv
// ---------------------------------------------------------------------------
// prd_decode
// input register and packbits row state, one item per cycle while the result stage is free
// ---------------------------------------------------------------------------
module prd_decode (
  input  logic                clk,
  input  logic                rst_n,
  prd_in_if.sink              in_if,
  input  logic                nibble_mode,
  input  logic [11:0]         row_width,
  input  logic                s2_free,
  output prd_pkg::dec_out_t   dec,
  output prd_pkg::pal_req_t   pal
);
  import prd_pkg::*;

  logic        s1_v_r;
  in_item_t    s1_r;
  logic        go;

  logic [15:0] bytes_rem_r, bytes_rem_nxt;
  logic [11:0] pix_rem_r, pix_rem_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  pend_r, pend_nxt;

  assign go          = s1_v_r && s2_free;
  assign in_if.ready = !s1_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_r.action         <= action_t'(in_if.action);
      s1_r.data_byte      <= in_if.data_byte;
      s1_r.palette_index  <= in_if.palette_index;
      s1_r.palette_value  <= in_if.palette_value;
      s1_r.row_byte_count <= in_if.row_byte_count;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [10:0] avail;
    logic [7:0]  m;
    logic [8:0]  cnt;
    logic [11:0] w;

    b             = s1_r.data_byte;
    avail         = pix_rem_r[11:1];
    m             = 8'd0;
    cnt           = 9'd0;
    w             = (32'(row_width) > MAX_ROW_WIDTH) ? 12'(MAX_ROW_WIDTH) : row_width;
    bytes_rem_nxt = bytes_rem_r;
    pix_rem_nxt   = pix_rem_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    dec           = '0;
    dec.go        = go;
    pal           = '0;
    pal.re        = go;
    pal.widx      = s1_r.palette_index;
    pal.wval      = s1_r.palette_value;
    pal.ridx0     = b;
    pal.ridx1     = b;

    case (s1_r.action)
      ACT_PAL_WRITE: begin
        pal.we = go;
      end
      ACT_ROW_START: begin
        bytes_rem_nxt = s1_r.row_byte_count;
        pix_rem_nxt   = w;
        phase_nxt     = PH_HEADER;
        pend_nxt      = 8'd0;
      end
      ACT_ROW_DATA: begin
        if (phase_r != PH_DONE && bytes_rem_r != 16'd0 && pix_rem_r != 12'd0) begin
          bytes_rem_nxt = bytes_rem_r - 16'd1;
          case (phase_r)
            PH_HEADER: begin
              if ((b & HDR_RUN_BIT) != 8'd0) begin
                pend_nxt  = 8'(RUN_BASE - {1'b0, b});
                phase_nxt = PH_RUN;
              end else begin
                pend_nxt  = b + 8'd1;
                phase_nxt = PH_LITERAL;
              end
            end
            PH_RUN: begin
              if (nibble_mode) begin
                m         = ({3'b0, pend_r} < avail) ? pend_r : avail[7:0];
                cnt       = {m, 1'b0};
                pal.ridx0 = b >> NIB_SHIFT;
              end else begin
                m   = ({4'b0, pend_r} < pix_rem_r) ? pend_r : pix_rem_r[7:0];
                cnt = {1'b0, m};
              end
              dec.r0.count = cnt;
              dec.r0.col   = row_width - pix_rem_r;
              dec.n        = (cnt != 9'd0) ? 2'd1 : 2'd0;
              pix_rem_nxt  = pix_rem_r - 12'(cnt);
              phase_nxt    = PH_HEADER;
            end
            default: begin
              if (nibble_mode) begin
                if (pix_rem_r >= 12'd2) begin
                  pal.ridx0    = b >> NIB_SHIFT;
                  pal.ridx1    = b & NIB_MASK;
                  dec.r0.count = 9'd1;
                  dec.r0.col   = row_width - pix_rem_r;
                  dec.r1.count = 9'd1;
                  dec.r1.col   = row_width - (pix_rem_r - 12'd1);
                  dec.n        = 2'd2;
                  pix_rem_nxt  = pix_rem_r - 12'd2;
                end
              end else begin
                dec.r0.count = 9'd1;
                dec.r0.col   = row_width - pix_rem_r;
                dec.n        = 2'd1;
                pix_rem_nxt  = pix_rem_r - 12'd1;
              end
              pend_nxt = pend_r - 8'd1;
              if (pend_nxt == 8'd0) begin
                phase_nxt = PH_HEADER;
              end
            end
          endcase
          if (bytes_rem_nxt == 16'd0 || pix_rem_nxt == 12'd0) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_rem_r <= 16'd0;
      pix_rem_r   <= 12'd0;
      phase_r     <= PH_HEADER;
      pend_r      <= 8'd0;
    end else if (go) begin
      bytes_rem_r <= bytes_rem_nxt;
      pix_rem_r   <= pix_rem_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

>>> sv/prd_emit.sv
// ---------------------------------------------------------------------------
// prd_emit
// result stage and output register, one color run per cycle while the output is not stalled
// ---------------------------------------------------------------------------
module prd_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  prd_pkg::dec_out_t  dec,
  input  logic [7:0]         color0,
  input  logic [7:0]         color1,
  output logic               s2_free,
  prd_out_if.source          out_if
);
  import prd_pkg::*;

  logic        v2_r, two_r, sel_r;
  res_t        r0_r, r1_r;
  logic        ov_r;
  logic [7:0]  color_r;
  res_t        res_r;
  logic        last_r;
  logic        load_out, leaving;

  assign load_out = v2_r && (!ov_r || out_if.ready);
  assign leaving  = load_out && (!two_r || sel_r);
  assign s2_free  = !v2_r || leaving;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      sel_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (dec.go && dec.n != 2'd0) begin
        v2_r  <= 1'b1;
        sel_r <= 1'b0;
      end else if (leaving) begin
        v2_r  <= 1'b0;
      end else if (load_out) begin
        sel_r <= 1'b1;
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec.go && dec.n != 2'd0) begin
      two_r <= dec.n == 2'd2;
      r0_r  <= dec.r0;
      r1_r  <= dec.r1;
    end
    if (load_out) begin
      color_r <= sel_r ? color1 : color0;
      res_r   <= sel_r ? r1_r : r0_r;
      last_r  <= !two_r || sel_r;
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.pixel_color  = color_r;
  assign out_if.repeat_count = res_r.count;
  assign out_if.start_column = res_r.col;
  assign out_if.last         = last_r;

endmodule

>>> sv/packbits_row_decoder_with_palette.sv
// ---------------------------------------------------------------------------
// packbits_row_decoder_with_palette
// packbits row decoder with palette lookup, emits color runs per row
// ---------------------------------------------------------------------------
//  channel  dir  carries
//  in_if    in   palette write, row start or packed row byte
//  out_if   out  color run: color, repeat count, start column, last
//  cfg_if   in   register write: nibble_mode (0), row_width (1)
//
//  an item passes from the input register to the result stage, its runs then to the output register
//  one item per cycle while the output is not stalled; a nibble literal byte (two runs)
//  holds the result stage for both; the single output register, one run per cycle, sets the rate
//  synchronous reset, palette contents undefined until written, no clear pass
//  a stalled output holds the result stage, then the input register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module packbits_row_decoder_with_palette (
  input  logic       clk,
  input  logic       rst_n,
  prd_in_if.sink     in_if,
  prd_out_if.source  out_if,
  prd_cfg_if.sink    cfg_if
);
  import prd_pkg::*;

  logic        nibble_mode_r;
  logic [11:0] row_width_r;
  logic        s2_free;
  dec_out_t    dec;
  pal_req_t    pal;
  logic [7:0]  color0, color1;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_mode_r <= 1'b0;
      row_width_r   <= 12'd320;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_NIBBLE_MODE: nibble_mode_r <= cfg_if.data[0];
        CFG_ROW_WIDTH:   row_width_r   <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  prd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .nibble_mode (nibble_mode_r),
    .row_width   (row_width_r),
    .s2_free     (s2_free),
    .dec         (dec),
    .pal         (pal)
  );

  prd_palette u_palette (
    .clk    (clk),
    .req    (pal),
    .rdata0 (color0),
    .rdata1 (color1)
  );

  prd_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec     (dec),
    .color0  (color0),
    .color1  (color1),
    .s2_free (s2_free),
    .out_if  (out_if)
  );

  // a palette write never produces a run
  `ASSERT_IMPLIES(a_pal_no_run, clk, rst_n, dec.go && pal.we, dec.n == 2'd0)
  // no run of zero pixels leaves the block
  `ASSERT_IMPLIES(a_run_nonzero, clk, rst_n, out_if.valid, out_if.repeat_count != 9'd0)
  // nibble runs longer than one pixel cover whole pixel pairs
  `ASSERT_IMPLIES(a_nib_even, clk, rst_n,
                  out_if.valid && nibble_mode_r && out_if.repeat_count != 9'd1,
                  out_if.repeat_count[0] == 1'b0)

endmodule
